/* sv/tiba_pkg.sv */
`default_nettype none
package tiba_pkg;

  localparam int DEF_STORE_DEPTH  = 65536;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int ADDR_WIDTH       = 16;
  localparam int GAIN_WIDTH       = 16;
  localparam int COEF_WIDTH       = 16;
  localparam int CAP_WIDTH        = 8;
  localparam int CFG_IDX_WIDTH    = 3;
  localparam int CFG_DATA_WIDTH   = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int OUT_DEPTH        = 8;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_HIGH_FB   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HIGH_CUR  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HIGH_PREV = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOW_FB    = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOW_CUR   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOW_PREV  = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_CAP  = 3'd6;

  localparam logic [CAP_WIDTH-1:0] GAIN_CAP_RESET = 8'd10;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] high_fb;
    logic signed [COEF_WIDTH-1:0] high_cur;
    logic signed [COEF_WIDTH-1:0] high_prev;
    logic signed [COEF_WIDTH-1:0] low_fb;
    logic signed [COEF_WIDTH-1:0] low_cur;
    logic signed [COEF_WIDTH-1:0] low_prev;
    logic [CAP_WIDTH-1:0]         gain_cap;
  } tiba_cfg_t;

endpackage
`default_nettype wire

/* sv/temporal_iir_bandpass_amplifier.sv */
// Temporal IIR band-pass amplifier, one pyramid coefficient per request.
// Input channel: push/full. A request (coefficient, address, band gain,
// mute, prime) is taken at a clock edge with push high and full low.
// Result channel: empty/pop. The oldest result (amplified, out_address)
// is shown while empty is low and is taken on an edge with pop high.
// Config channel: cfg_valid_i/cfg_ready_o with index and data; ready is
// always high. Write registers only while the block is idle.
// Throughput: one request per cycle while its state slot (address mod
// depth) differs from those of the two requests issued just before it
// and the result queue has room. The slot state is read at issue into
// stage A and written back from stage B, so a matching request waits for
// that write-back. Results pass stages A to D into the result queue.
// A stalled receiver fills the 8-entry result queue; issue then stops,
// the 4-entry request queue fills and full rises. Nothing is dropped.
// Reset clears the queues and the pipeline and sets the registers to
// their defaults; the filter state memories are not cleared and must be
// loaded by a prime request before an address is used.
`default_nettype none
module temporal_iir_bandpass_amplifier import tiba_pkg::*; #(
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_WIDTH-1:0]      cfg_data_i,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [SAMPLE_WIDTH-1:0] coefficient_i,
  input  wire logic [ADDR_WIDTH-1:0]          address_i,
  input  wire logic [GAIN_WIDTH-1:0]          band_gain_i,
  input  wire logic                           band_muted_i,
  input  wire logic                           prime_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0]      amplified_o,
  output logic [ADDR_WIDTH-1:0]               out_address_o
);

  localparam int SLOT_W = $clog2(STORE_DEPTH);

  tiba_cfg_t                      cfg;
  logic                           q_valid, q_pop;
  logic signed [SAMPLE_WIDTH-1:0] q_cur;
  logic [ADDR_WIDTH-1:0]          q_addr;
  logic [GAIN_WIDTH-1:0]          q_gain;
  logic                           q_muted, q_prime;
  logic [SLOT_W-1:0]              q_slot;

  tiba_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tiba_front #(
    .STORE_DEPTH  (STORE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .coefficient_i (coefficient_i),
    .address_i     (address_i),
    .band_gain_i   (band_gain_i),
    .band_muted_i  (band_muted_i),
    .prime_i       (prime_i),
    .q_pop_i       (q_pop),
    .q_valid_o     (q_valid),
    .q_cur_o       (q_cur),
    .q_addr_o      (q_addr),
    .q_gain_o      (q_gain),
    .q_muted_o     (q_muted),
    .q_prime_o     (q_prime),
    .q_slot_o      (q_slot)
  );

  tiba_back #(
    .STORE_DEPTH  (STORE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_cur_i       (q_cur),
    .q_addr_i      (q_addr),
    .q_gain_i      (q_gain),
    .q_muted_i     (q_muted),
    .q_prime_i     (q_prime),
    .q_slot_i      (q_slot),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .amplified_o   (amplified_o),
    .out_address_o (out_address_o)
  );

endmodule
`default_nettype wire

/* sv/tiba_regs.sv */
`default_nettype none
module tiba_regs import tiba_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  output tiba_cfg_t                      cfg_o
);

  tiba_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{high_fb:   '0,
                 high_cur:  '0,
                 high_prev: '0,
                 low_fb:    '0,
                 low_cur:   '0,
                 low_prev:  '0,
                 gain_cap:  GAIN_CAP_RESET};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HIGH_FB:   cfg_q.high_fb   <= cfg_data_i;
        REG_HIGH_CUR:  cfg_q.high_cur  <= cfg_data_i;
        REG_HIGH_PREV: cfg_q.high_prev <= cfg_data_i;
        REG_LOW_FB:    cfg_q.low_fb    <= cfg_data_i;
        REG_LOW_CUR:   cfg_q.low_cur   <= cfg_data_i;
        REG_LOW_PREV:  cfg_q.low_prev  <= cfg_data_i;
        REG_GAIN_CAP:  cfg_q.gain_cap  <= cfg_data_i[CAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/tiba_front.sv */
`default_nettype none
module tiba_front import tiba_pkg::*; #(
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int SLOT_W      = $clog2(STORE_DEPTH)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [SAMPLE_WIDTH-1:0] coefficient_i,
  input  wire logic [ADDR_WIDTH-1:0]          address_i,
  input  wire logic [GAIN_WIDTH-1:0]          band_gain_i,
  input  wire logic                           band_muted_i,
  input  wire logic                           prime_i,
  input  wire logic                           q_pop_i,
  output logic                                q_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]      q_cur_o,
  output logic [ADDR_WIDTH-1:0]               q_addr_o,
  output logic [GAIN_WIDTH-1:0]               q_gain_o,
  output logic                                q_muted_o,
  output logic                                q_prime_o,
  output logic [SLOT_W-1:0]                   q_slot_o
);

  localparam logic [32:0] RECIP   = 33'(((64'd1 << 32) + 64'(STORE_DEPTH) - 64'd1)
                                        / 64'(STORE_DEPTH));
  localparam logic [22:0] DEPTH_C = 23'(STORE_DEPTH);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                           f1_v_q;
  logic signed [SAMPLE_WIDTH-1:0] f1_cur_q;
  logic [ADDR_WIDTH-1:0]          f1_addr_q;
  logic [GAIN_WIDTH-1:0]          f1_gain_q;
  logic                           f1_muted_q;
  logic                           f1_prime_q;
  logic [ADDR_WIDTH-1:0]          f1_quo_q;
  logic [48:0]                    quo_prod;
  logic [38:0]                    slot_full;
  logic [SLOT_W-1:0]              f1_slot;
  logic                           accept;

  logic signed [SAMPLE_WIDTH-1:0] cur_mem   [QUEUE_DEPTH];
  logic [ADDR_WIDTH-1:0]          addr_mem  [QUEUE_DEPTH];
  logic [GAIN_WIDTH-1:0]          gain_mem  [QUEUE_DEPTH];
  logic                           muted_mem [QUEUE_DEPTH];
  logic                           prime_mem [QUEUE_DEPTH];
  logic [SLOT_W-1:0]              slot_mem  [QUEUE_DEPTH];
  logic [QPTR_W-1:0]              wptr_q, rptr_q;
  logic [QCNT_W-1:0]              cnt_q, cnt_d;
  logic                           q_pop;

  assign full     = ({1'b0, cnt_q} + (QCNT_W + 1)'(f1_v_q)) >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = push && !full;
  assign quo_prod = 49'(address_i) * 49'(RECIP);

  // slot = address mod depth via exact reciprocal quotient
  assign slot_full = 39'(f1_addr_q) - 39'(f1_quo_q) * 39'(DEPTH_C);
  assign f1_slot   = slot_full[SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_cur_q   <= coefficient_i;
      f1_addr_q  <= address_i;
      f1_gain_q  <= band_gain_i;
      f1_muted_q <= band_muted_i;
      f1_prime_q <= prime_i;
      f1_quo_q   <= quo_prod[47:32];
    end
  end

  assign q_pop     = q_pop_i && (cnt_q != '0);
  assign q_valid_o = (cnt_q != '0);
  assign q_cur_o   = cur_mem[rptr_q];
  assign q_addr_o  = addr_mem[rptr_q];
  assign q_gain_o  = gain_mem[rptr_q];
  assign q_muted_o = muted_mem[rptr_q];
  assign q_prime_o = prime_mem[rptr_q];
  assign q_slot_o  = slot_mem[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (f1_v_q && !q_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!f1_v_q && q_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (f1_v_q) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (q_pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_v_q) begin
      cur_mem[wptr_q]   <= f1_cur_q;
      addr_mem[wptr_q]  <= f1_addr_q;
      gain_mem[wptr_q]  <= f1_gain_q;
      muted_mem[wptr_q] <= f1_muted_q;
      prime_mem[wptr_q] <= f1_prime_q;
      slot_mem[wptr_q]  <= f1_slot;
    end
  end

endmodule
`default_nettype wire

/* sv/tiba_back.sv */
`default_nettype none
module tiba_back import tiba_pkg::*; #(
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int SLOT_W      = $clog2(STORE_DEPTH)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  tiba_cfg_t                           cfg_i,
  input  wire logic                           q_valid_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] q_cur_i,
  input  wire logic [ADDR_WIDTH-1:0]          q_addr_i,
  input  wire logic [GAIN_WIDTH-1:0]          q_gain_i,
  input  wire logic                           q_muted_i,
  input  wire logic                           q_prime_i,
  input  wire logic [SLOT_W-1:0]              q_slot_i,
  output logic                                q_pop_o,
  output logic                                empty,
  input  wire logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0]      amplified_o,
  output logic [ADDR_WIDTH-1:0]               out_address_o
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int LPW    = SW + 8;
  localparam int FBW    = COEF_WIDTH + LPW;
  localparam int CAW    = COEF_WIDTH + SW;
  localparam int ACCW   = SW + 28;
  localparam int DW     = LPW + 1;
  localparam int PW     = DW + GAIN_WIDTH + 2;
  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic signed [ACCW-1:0] LP_MAX  = ACCW'((64'sd1 <<< (LPW - 1)) - 64'sd1);
  localparam logic signed [ACCW-1:0] LP_MIN  = ACCW'(-(64'sd1 <<< (LPW - 1)));
  localparam logic signed [ACCW-1:0] ACC_RND = ACCW'(64'sd1 <<< 13);
  localparam logic signed [PW-1:0]   S_MAX   = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [PW-1:0]   S_MIN   = PW'(-(64'sd1 <<< (SW - 1)));
  localparam logic signed [PW-1:0]   P_RND   = PW'(64'sd1 <<< 15);

  logic [LPW-1:0] up_mem [STORE_DEPTH];
  logic [LPW-1:0] lo_mem [STORE_DEPTH];
  logic [SW-1:0]  pv_mem [STORE_DEPTH];

  logic                  issue, hazard;
  logic [OCNT_W:0]       credit_use;
  logic [OCNT_W-1:0]     ocnt_q, ocnt_d;
  logic [OPTR_W-1:0]     owptr_q, orptr_q;
  logic signed [SW-1:0]  oamp_mem  [OUT_DEPTH];
  logic [ADDR_WIDTH-1:0] oaddr_mem [OUT_DEPTH];
  logic                  opop;

  // stage A: state read back
  logic                  a_v_q;
  logic [SLOT_W-1:0]     a_slot_q;
  logic signed [SW-1:0]  a_cur_q;
  logic [ADDR_WIDTH-1:0] a_addr_q;
  logic [GAIN_WIDTH-1:0] a_gain_q;
  logic                  a_muted_q, a_prime_q;
  logic signed [LPW-1:0] a_up_q, a_lo_q;
  logic signed [SW-1:0]  a_pv_q;

  // stage B: products
  logic                  b_v_q;
  logic [SLOT_W-1:0]     b_slot_q;
  logic signed [SW-1:0]  b_cur_q;
  logic [ADDR_WIDTH-1:0] b_addr_q;
  logic [GAIN_WIDTH-1:0] b_gain_q;
  logic                  b_muted_q, b_prime_q;
  logic signed [FBW-1:0] b_hfb_q, b_lfb_q;
  logic signed [CAW-1:0] b_h0_q, b_h1_q, b_l0_q, b_l1_q;
  logic signed [ACCW-1:0] acc_h, acc_l, sh_h, sh_l;
  logic signed [LPW-1:0]  up_new, lo_new, up_wr, lo_wr;
  logic [GAIN_WIDTH-1:0]  cap_g, g_sel;

  // stage C: gain product
  logic                   c_v_q, c_zero_q;
  logic [ADDR_WIDTH-1:0]  c_addr_q;
  logic signed [LPW-1:0]  c_up_q, c_lo_q;
  logic [GAIN_WIDTH-1:0]  c_g_q;
  logic signed [DW-1:0]   diff;

  // stage D: round and saturate
  logic                   d_v_q, d_zero_q;
  logic [ADDR_WIDTH-1:0]  d_addr_q;
  logic signed [PW-1:0]   d_p_q, p_sh;
  logic signed [SW-1:0]   amp;

  assign hazard = (a_v_q && (a_slot_q == q_slot_i)) || (b_v_q && (b_slot_q == q_slot_i));
  assign credit_use = {1'b0, ocnt_q} + (OCNT_W + 1)'(a_v_q) + (OCNT_W + 1)'(b_v_q)
                    + (OCNT_W + 1)'(c_v_q) + (OCNT_W + 1)'(d_v_q);
  assign issue   = q_valid_i && !hazard && (credit_use < (OCNT_W + 1)'(OUT_DEPTH));
  assign q_pop_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      a_v_q <= issue;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_slot_q  <= q_slot_i;
    a_cur_q   <= q_cur_i;
    a_addr_q  <= q_addr_i;
    a_gain_q  <= q_gain_i;
    a_muted_q <= q_muted_i;
    a_prime_q <= q_prime_i;
    if (issue) begin
      a_up_q <= up_mem[q_slot_i];
      a_lo_q <= lo_mem[q_slot_i];
      a_pv_q <= pv_mem[q_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    b_slot_q  <= a_slot_q;
    b_cur_q   <= a_cur_q;
    b_addr_q  <= a_addr_q;
    b_gain_q  <= a_gain_q;
    b_muted_q <= a_muted_q;
    b_prime_q <= a_prime_q;
    b_hfb_q   <= FBW'(cfg_i.high_fb) * FBW'(a_up_q);
    b_lfb_q   <= FBW'(cfg_i.low_fb) * FBW'(a_lo_q);
    b_h0_q    <= CAW'(cfg_i.high_cur) * CAW'(a_cur_q);
    b_h1_q    <= CAW'(cfg_i.high_prev) * CAW'(a_pv_q);
    b_l0_q    <= CAW'(cfg_i.low_cur) * CAW'(a_cur_q);
    b_l1_q    <= CAW'(cfg_i.low_prev) * CAW'(a_pv_q);
  end

  always_comb begin
    acc_h = ACCW'(b_hfb_q) + ((ACCW'(b_h0_q) + ACCW'(b_h1_q)) <<< 8) + ACC_RND;
    acc_l = ACCW'(b_lfb_q) + ((ACCW'(b_l0_q) + ACCW'(b_l1_q)) <<< 8) + ACC_RND;
    sh_h  = acc_h >>> 14;
    sh_l  = acc_l >>> 14;
    if (sh_h > LP_MAX) begin
      up_new = LP_MAX[LPW-1:0];
    end else if (sh_h < LP_MIN) begin
      up_new = LP_MIN[LPW-1:0];
    end else begin
      up_new = sh_h[LPW-1:0];
    end
    if (sh_l > LP_MAX) begin
      lo_new = LP_MAX[LPW-1:0];
    end else if (sh_l < LP_MIN) begin
      lo_new = LP_MIN[LPW-1:0];
    end else begin
      lo_new = sh_l[LPW-1:0];
    end
    if (b_prime_q) begin
      up_wr = {b_cur_q, 8'd0};
      lo_wr = {b_cur_q, 8'd0};
    end else begin
      up_wr = up_new;
      lo_wr = lo_new;
    end
    cap_g = {cfg_i.gain_cap, 8'd0};
    g_sel = (b_gain_q > cap_g) ? cap_g : b_gain_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_v_q) begin
      up_mem[b_slot_q] <= up_wr;
      lo_mem[b_slot_q] <= lo_wr;
      pv_mem[b_slot_q] <= b_cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_up_q   <= up_new;
    c_lo_q   <= lo_new;
    c_g_q    <= g_sel;
    c_zero_q <= b_prime_q || b_muted_q;
    c_addr_q <= b_addr_q;
  end

  assign diff = DW'(c_up_q) - DW'(c_lo_q);

  always_ff @(posedge clk_i) begin
    d_p_q    <= PW'(diff) * $signed(PW'(c_g_q));
    d_zero_q <= c_zero_q;
    d_addr_q <= c_addr_q;
  end

  always_comb begin
    p_sh = (d_p_q + P_RND) >>> 16;
    if (d_zero_q) begin
      amp = '0;
    end else if (p_sh > S_MAX) begin
      amp = S_MAX[SW-1:0];
    end else if (p_sh < S_MIN) begin
      amp = S_MIN[SW-1:0];
    end else begin
      amp = p_sh[SW-1:0];
    end
  end

  assign empty         = (ocnt_q == '0);
  assign opop          = pop && !empty;
  assign amplified_o   = oamp_mem[orptr_q];
  assign out_address_o = oaddr_mem[orptr_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (d_v_q && !opop) begin
      ocnt_d = ocnt_q + OCNT_W'(1);
    end else if (!d_v_q && opop) begin
      ocnt_d = ocnt_q - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q  <= '0;
      owptr_q <= '0;
      orptr_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (d_v_q) begin
        owptr_q <= owptr_q + OPTR_W'(1);
      end
      if (opop) begin
        orptr_q <= orptr_q + OPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_v_q) begin
      oamp_mem[owptr_q]  <= amp;
      oaddr_mem[owptr_q] <= d_addr_q;
    end
  end

endmodule
`default_nettype wire

/* sim/temporal_iir_bandpass_amplifier_tb.sv */
`default_nettype none
module temporal_iir_bandpass_amplifier_tb;
  import tiba_pkg::*;

  typedef struct {
    logic signed [15:0] coef;
    logic [15:0]        addr;
    logic [15:0]        gain;
    logic               muted;
    logic               prime;
  } sample_req_t;

  typedef struct {
    logic signed [15:0] amp;
    logic [15:0]        addr;
  } amp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] coefficient_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] band_gain_i = '0;
  logic band_muted_i = 1'b0;
  logic prime_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] amplified_o;
  logic [15:0] out_address_o;

  temporal_iir_bandpass_amplifier dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_req_t pending_reqs[$];
  amp_result_t expected_amps[$];
  int errors = 0;
  bit driving = 1'b0;

  // predictor state
  logic signed [23:0] upper_lp [int];
  logic signed [23:0] lower_lp [int];
  logic signed [15:0] prev_smp [int];
  logic signed [15:0] coef_reg [6];
  logic [7:0] cap_reg = GAIN_CAP_RESET;
  bit primed [int];
  int primed_list[$];

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint lp_update(longint lp, longint cur, longint prv,
                                       longint fb, longint ca0, longint ca1);
    longint acc = fb * lp + (ca0 * cur + ca1 * prv) * 256 + 8192;
    return clamp(floor_shift(acc, 14), 24);
  endfunction

  function automatic amp_result_t predict_amp(sample_req_t r);
    amp_result_t res;
    longint up, lo, g, cap;
    int a = int'(r.addr);
    res.addr = r.addr;
    res.amp = '0;
    if (r.prime) begin
      upper_lp[a] = 24'(longint'(r.coef) * 256);
      lower_lp[a] = 24'(longint'(r.coef) * 256);
    end else begin
      up = lp_update(upper_lp[a], r.coef, prev_smp[a], coef_reg[REG_HIGH_FB],
                     coef_reg[REG_HIGH_CUR], coef_reg[REG_HIGH_PREV]);
      lo = lp_update(lower_lp[a], r.coef, prev_smp[a], coef_reg[REG_LOW_FB],
                     coef_reg[REG_LOW_CUR], coef_reg[REG_LOW_PREV]);
      upper_lp[a] = 24'(up);
      lower_lp[a] = 24'(lo);
      if (!r.muted) begin
        cap = longint'(cap_reg) * 256;
        g = (r.gain > cap) ? cap : longint'(r.gain);
        res.amp = 16'(clamp(floor_shift((up - lo) * g + 32768, 16), 16));
      end
    end
    prev_smp[a] = r.coef;
    return res;
  endfunction

  function automatic sample_req_t make_req(logic signed [15:0] c, logic [15:0] a,
                                          logic [15:0] g, logic m, logic p);
    sample_req_t r;
    r.coef = c; r.addr = a; r.gain = g; r.muted = m; r.prime = p;
    if (p && !primed.exists(int'(a))) begin
      primed[int'(a)] = 1'b1;
      primed_list = {primed_list, int'(a)};
    end
    return r;
  endfunction

  task automatic add_req(sample_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  logic full_q = 1'b0;
  always @(posedge clk_i) begin
    full_q <= full;
  end

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && driving) begin
      if (push && !full_q) begin
        expected_amps = {expected_amps, predict_amp(pending_reqs.pop_front())};
      end
      if (push && full_q) begin
        // hold request
      end else if (pending_reqs.size() == 0) begin
        push <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        push <= 1'b1;
        coefficient_i <= pending_reqs[0].coef;
        address_i <= pending_reqs[0].addr;
        band_gain_i <= pending_reqs[0].gain;
        band_muted_i <= pending_reqs[0].muted;
        prime_i <= pending_reqs[0].prime;
      end
    end
  end

  // receiver: stall pattern, mostly ready, occasional long stalls
  int stall_mode = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 99) < 3) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        2: pop <= ($urandom_range(0, 9) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    amp_result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (expected_amps.size() == 0) begin
        $error("unexpected result address %0d", out_address_o);
        errors++;
      end else begin
        exp_r = expected_amps.pop_front();
        if (amplified_o !== exp_r.amp) begin
          $error("amplified expected %0d actual %0d", exp_r.amp, amplified_o);
          errors++;
        end
        if (out_address_o !== exp_r.addr) begin
          $error("out_address expected %0d actual %0d", exp_r.addr, out_address_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_GAIN_CAP) cap_reg = val[7:0];
    else if (idx <= REG_LOW_PREV) coef_reg[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase();
    driving = 1'b1;
    wait (pending_reqs.size() == 0 && expected_amps.size() == 0);
    driving = 1'b0;
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_coefs(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                           logic [15:0] v3, logic [15:0] v4, logic [15:0] v5);
    write_reg(REG_HIGH_FB, v0);
    write_reg(REG_HIGH_CUR, v1);
    write_reg(REG_HIGH_PREV, v2);
    write_reg(REG_LOW_FB, v3);
    write_reg(REG_LOW_CUR, v4);
    write_reg(REG_LOW_PREV, v5);
  endtask

  // random well-formed stream: mostly primed addresses, some fresh primes
  task automatic queue_random(int n);
    logic [15:0] a, g;
    for (int i = 0; i < n; i++) begin
      if (primed_list.size() == 0 || $urandom_range(0, 9) == 0) begin
        a = (primed_list.size() > 0 && $urandom_range(0, 1)) ?
            16'(primed_list[$urandom_range(0, primed_list.size() - 1)]) : 16'($urandom);
        add_req(make_req(16'($urandom), a, 16'($urandom), 1'($urandom), 1'b1));
      end else begin
        a = 16'(primed_list[$urandom_range(0, primed_list.size() - 1)]);
        case ($urandom_range(0, 2))
          0: g = 16'($urandom);
          1: g = 16'($urandom_range(0, 4096));
          default: g = 16'hffff;
        endcase
        add_req(make_req(16'($urandom), a, g, $urandom_range(0, 7) == 0, 1'b0));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) coef_reg[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, extremes of fields, prime, mute, saturation
    add_req(make_req(16'sh7fff, 16'h0000, 16'hffff, 1'b0, 1'b1));
    add_req(make_req(-16'sd32768, 16'hffff, 16'h0000, 1'b1, 1'b1));
    add_req(make_req(16'sd100, 16'h0000, 16'hffff, 1'b0, 1'b0));
    run_phase();

    set_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    write_reg(REG_GAIN_CAP, 16'h00ff);
    add_req(make_req(16'sh7fff, 16'h0000, 16'hffff, 1'b0, 1'b0));
    add_req(make_req(-16'sd32768, 16'hffff, 16'hffff, 1'b0, 1'b0));
    add_req(make_req(16'sh7fff, 16'h0000, 16'h0001, 1'b0, 1'b0));
    add_req(make_req(16'sh1234, 16'hffff, 16'hffff, 1'b1, 1'b0));
    add_req(make_req(16'sh5555, 16'h0000, 16'h00ff, 1'b0, 1'b1));
    add_req(make_req(-16'sd1, 16'h0000, 16'h8000, 1'b0, 1'b0));
    add_req(make_req(16'sh2aaa, 16'h0000, 16'h7fff, 1'b0, 1'b0));
    run_phase();

    write_reg(REG_GAIN_CAP, 16'h0000);
    add_req(make_req(16'sh4000, 16'hffff, 16'hffff, 1'b0, 1'b0));
    run_phase();

    // typical band-pass settings, then random extremes
    set_coefs(16'h3000, 16'h0800, 16'h0800, 16'h3c00, 16'h0200, 16'h0200);
    write_reg(REG_GAIN_CAP, 16'd20);
    queue_random(130);
    run_phase();

    set_coefs(16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
    write_reg(REG_GAIN_CAP, 16'($urandom));
    queue_random(130);
    run_phase();

    set_coefs(16'h4000, 16'h0000, 16'h0000, 16'hc000, 16'h7fff, 16'h8000);
    write_reg(REG_GAIN_CAP, 16'd1);
    queue_random(130);
    run_phase();

    if (errors == 0) begin
      $display("temporal_iir_bandpass_amplifier: match");
    end else begin
      $display("temporal_iir_bandpass_amplifier: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("temporal_iir_bandpass_amplifier: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/tiba_pkg.sv
sv/tiba_regs.sv
sv/tiba_front.sv
sv/tiba_back.sv
sv/temporal_iir_bandpass_amplifier.sv
sim/temporal_iir_bandpass_amplifier_tb.sv
